@@ rtl/core/asc_pkg.sv @@
// Shared constants and types for the box/sphere contact pipeline.
// No dependencies; imported by the axis unit and the top level.
package asc_pkg;

  localparam int COORD_WIDTH_DEF = 32;  // default coordinate width (signed fixed point)
  localparam int NUM_AXES        = 3;

  // Axis codes as reported on the result normal_axis field
  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

endpackage

@@ rtl/core/asc_axis.sv @@
// Per-axis geometry, two register stages: box interval, sphere interval,
// clamped gap, interval overlap and normal direction.
// Depends on asc_pkg.
module asc_axis
  import asc_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic [1:0]                    en_i,           // load enables, stage 1 and 2
  input  logic signed [COORD_WIDTH-1:0] box_center_i,
  input  logic [COORD_WIDTH-2:0]        box_half_i,
  input  logic signed [COORD_WIDTH-1:0] ball_center_i,
  input  logic [COORD_WIDTH-2:0]        ball_radius_i,
  output logic [COORD_WIDTH:0]          gap_o,          // distance from center to box
  output logic [COORD_WIDTH:0]          overlap_o,      // interval overlap, floored at 0
  output logic                          neg_o           // box center above ball center
);

  localparam int XW = COORD_WIDTH + 2;

  logic signed [XW-1:0] bc_x, bh_x, sc_x, rad_x;
  logic signed [XW-1:0] mn_q, mx_q, top_q, bot_q, sc_q;
  logic                 neg1_q;

  logic signed [XW-1:0] dlo, dhi, hi_sel, lo_sel, ov_diff;
  logic [COORD_WIDTH:0] gap_d, ov_d;

  assign bc_x  = {{2{box_center_i[COORD_WIDTH-1]}}, box_center_i};
  assign sc_x  = {{2{ball_center_i[COORD_WIDTH-1]}}, ball_center_i};
  assign bh_x  = {3'b000, box_half_i};
  assign rad_x = {3'b000, ball_radius_i};

  // stage 1: interval ends
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      mn_q   <= bc_x - bh_x;
      mx_q   <= bc_x + bh_x;
      top_q  <= sc_x + rad_x;
      bot_q  <= sc_x - rad_x;
      sc_q   <= sc_x;
      neg1_q <= (box_center_i > ball_center_i);
    end
  end

  // stage 2: gap and overlap
  always_comb begin
    dlo     = mn_q - sc_q;
    dhi     = sc_q - mx_q;
    hi_sel  = (mx_q < top_q) ? mx_q : top_q;
    lo_sel  = (mn_q > bot_q) ? mn_q : bot_q;
    ov_diff = hi_sel - lo_sel;
    if (!dlo[XW-1] && (dlo != '0)) begin
      gap_d = dlo[COORD_WIDTH:0];
    end else if (!dhi[XW-1] && (dhi != '0)) begin
      gap_d = dhi[COORD_WIDTH:0];
    end else begin
      gap_d = '0;
    end
    ov_d = ov_diff[XW-1] ? '0 : ov_diff[COORD_WIDTH:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      gap_o     <= gap_d;
      overlap_o <= ov_d;
      neg_o     <= neg1_q;
    end
  end

endmodule

@@ rtl/core/asc_square.sv @@
// Two-stage exact squarer: half-width partial products, then assembly.
// No dependencies.
module asc_square #(
  parameter int WIDTH = 33
) (
  input  logic               clk_i,
  input  logic [1:0]         en_i,     // load enables: partials, result
  input  logic [WIDTH-1:0]   a_i,
  output logic [2*WIDTH-1:0] sq_o
);

  localparam int K = (WIDTH + 1) / 2;  // low part width
  localparam int H = WIDTH - K;        // high part width

  logic [K-1:0]     a_lo;
  logic [H-1:0]     a_hi;
  logic [2*K-1:0]   p_ll_q;
  logic [H+K-1:0]   p_lh_q;
  logic [2*H-1:0]   p_hh_q;
  logic [2*WIDTH-1:0] ll_x, lh_x, hh_x;

  assign a_lo = a_i[K-1:0];
  assign a_hi = a_i[WIDTH-1:K];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      p_ll_q <= (2*K)'(a_lo) * (2*K)'(a_lo);
      p_lh_q <= (H+K)'(a_hi) * (H+K)'(a_lo);
      p_hh_q <= (2*H)'(a_hi) * (2*H)'(a_hi);
    end
  end

  // a^2 = hh<<2K + 2*lh<<K + ll
  assign ll_x = {{(2*WIDTH-2*K){1'b0}}, p_ll_q};
  assign lh_x = {{(2*WIDTH-H-K){1'b0}}, p_lh_q} << (K + 1);
  assign hh_x = {{(2*WIDTH-2*H){1'b0}}, p_hh_q} << (2 * K);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      sq_o <= hh_x + lh_x + ll_x;
    end
  end

endmodule

@@ rtl/core/aabb_sphere_collision.sv @@
// Box/sphere contact test, top level: stream ports, stage valids, min-axis
// pick, squared-distance sum and hit decision. Depends on asc_pkg, asc_axis, asc_square.
//
// Takes one axis-aligned box (center, half extents) and one sphere (center,
// radius) per transfer, all signed fixed point of COORD_WIDTH bits (half sizes
// and radius COORD_WIDTH-1 bits unsigned), and returns one result per transfer:
// hit when the squared clamped center-to-box distance is at most the squared
// radius, and on a hit the axis of least interval overlap (ties to x, then y),
// the normal sign (set when box center exceeds sphere center on that axis) and
// that overlap as penetration; a miss returns all zeros. Arithmetic is exact,
// nothing rounds or saturates. The block is a six-stage pipeline: one transfer
// per cycle in and out while the output is not stalled. Each full stage holds when
// the stage after it is full and stalled, so bubbles collapse and the input keeps
// accepting while a result waits at the output register, until all stages are full.
// Stage 1-2: per-axis intervals, gaps and overlaps. Stage 3-4: squares split into
// half-width partial products, and in stage 3 the least-overlap axis pick. Stage 5:
// sum of squared gaps. Stage 6: compare with squared radius into the output register.
module aabb_sphere_collision
  import asc_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,

  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // tdata, from bit 0: box_center_x/y/z, box_half_x/y/z, ball_center_x/y/z,
  // ball_radius, then zero fill to whole bytes
  input  logic [((10*COORD_WIDTH-4+7)/8)*8-1:0] s_axis_tdata_i,

  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // tdata, from bit 0: hit, normal_axis[1:0], normal_negative,
  // penetration, then zero fill to whole bytes
  output logic [((COORD_WIDTH+5+7)/8)*8-1:0] m_axis_tdata_o
);

  localparam int CW      = COORD_WIDTH;
  localparam int GW      = CW + 1;          // gap / overlap width
  localparam int RW      = CW - 1;          // radius width
  localparam int SW      = 2 * GW + 2;      // sum of three squared gaps
  localparam int STAGES  = 6;
  localparam int OUT_W   = ((CW + 5 + 7) / 8) * 8;
  localparam int OUT_PAD = OUT_W - (CW + 5);

  // ---------------- input unpack ----------------
  logic signed [CW-1:0] bc [NUM_AXES];
  logic [RW-1:0]        bh [NUM_AXES];
  logic signed [CW-1:0] sc [NUM_AXES];
  logic [RW-1:0]        rad;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_unpack
    assign bc[a] = s_axis_tdata_i[a*CW +: CW];
    assign bh[a] = s_axis_tdata_i[3*CW + a*RW +: RW];
    assign sc[a] = s_axis_tdata_i[3*CW + 3*RW + a*CW +: CW];
  end
  assign rad = s_axis_tdata_i[6*CW + 3*RW +: RW];

  // ---------------- stage control ----------------
  // A stage loads when it is empty or the stage after it moves.
  logic [STAGES-1:0] vld_q, vld_d, en;

  always_comb begin
    en[STAGES-1] = !vld_q[STAGES-1] || m_axis_tready_i;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
    vld_d[0] = en[0] ? s_axis_tvalid_i : vld_q[0];
    for (int k = 1; k < STAGES; k++) begin
      vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready_o = en[0];
  assign m_axis_tvalid_o = vld_q[STAGES-1];

  // ---------------- stages 1-2: per-axis geometry ----------------
  logic [GW-1:0]       gap [NUM_AXES];
  logic [GW-1:0]       ov  [NUM_AXES];
  logic [NUM_AXES-1:0] nneg;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    asc_axis #(
      .COORD_WIDTH(CW)
    ) u_axis (
      .clk_i        (clk_i),
      .en_i         (en[1:0]),
      .box_center_i (bc[a]),
      .box_half_i   (bh[a]),
      .ball_center_i(sc[a]),
      .ball_radius_i(rad),
      .gap_o        (gap[a]),
      .overlap_o    (ov[a]),
      .neg_o        (nneg[a])
    );
  end

  // radius rides along until the squarer
  logic [RW-1:0] rad1_q, rad2_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      rad1_q <= rad;
    end
    if (en[1]) begin
      rad2_q <= rad1_q;
    end
  end

  // ---------------- stages 3-4: squares ----------------
  logic [2*GW-1:0] gsq [NUM_AXES];
  logic [2*RW-1:0] rsq;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_sq
    asc_square #(
      .WIDTH(GW)
    ) u_gsq (
      .clk_i(clk_i),
      .en_i (en[3:2]),
      .a_i  (gap[a]),
      .sq_o (gsq[a])
    );
  end

  asc_square #(
    .WIDTH(RW)
  ) u_rsq (
    .clk_i(clk_i),
    .en_i (en[3:2]),
    .a_i  (rad2_q),
    .sq_o (rsq)
  );

  // ---------------- stage 3: least overlap axis ----------------
  logic [GW-1:0] best_xy;
  axis_e         axis_xy;
  logic [GW-1:0] best_d;
  axis_e         axis_d;
  logic          neg_d;

  always_comb begin
    if (ov[0] > ov[1]) begin
      best_xy = ov[1];
      axis_xy = AXIS_Y;
    end else begin
      best_xy = ov[0];
      axis_xy = AXIS_X;
    end
    if (best_xy > ov[2]) begin
      best_d = ov[2];
      axis_d = AXIS_Z;
    end else begin
      best_d = best_xy;
      axis_d = axis_xy;
    end
    case (axis_d)
      AXIS_X:  neg_d = nneg[0];
      AXIS_Y:  neg_d = nneg[1];
      AXIS_Z:  neg_d = nneg[2];
      default: neg_d = 1'b0;
    endcase
  end

  logic [GW-1:0] best3_q, best4_q, best5_q;
  axis_e         axis3_q, axis4_q, axis5_q;
  logic          neg3_q, neg4_q, neg5_q;
  logic [SW-1:0] sum5_q;
  logic [2*RW-1:0] rsq5_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      best3_q <= best_d;
      axis3_q <= axis_d;
      neg3_q  <= neg_d;
    end
    if (en[3]) begin
      best4_q <= best3_q;
      axis4_q <= axis3_q;
      neg4_q  <= neg3_q;
    end
    // stage 5: squared distance
    if (en[4]) begin
      best5_q <= best4_q;
      axis5_q <= axis4_q;
      neg5_q  <= neg4_q;
      sum5_q  <= {2'b00, gsq[0]} + {2'b00, gsq[1]} + {2'b00, gsq[2]};
      rsq5_q  <= rsq;
    end
  end

  // ---------------- stage 6: decision, output register ----------------
  logic          hit_d;
  logic          hit_q;
  axis_e         axis6_q;
  logic          neg6_q;
  logic [GW-1:0] pen6_q;

  // touching counts as a hit
  assign hit_d = (sum5_q <= {{(SW-2*RW){1'b0}}, rsq5_q});

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      hit_q   <= hit_d;
      axis6_q <= hit_d ? axis5_q : AXIS_X;
      neg6_q  <= hit_d && neg5_q;
      pen6_q  <= hit_d ? best5_q : '0;
    end
  end

  assign m_axis_tdata_o = {{OUT_PAD{1'b0}}, pen6_q, neg6_q, axis6_q, hit_q};

endmodule
